// ===== rtl/dda_pkg.sv =====
// Shared constants, codes and controller-datapath interface types of the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COORD_BITS    = 16;

    localparam int IN_W      = 16;
    localparam int PIX_W     = 16;
    localparam int DIM_W     = 13;
    localparam int ADDR_W    = 24;
    localparam int PAINT_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam int POS_W   = COORD_BITS + FRACTION_BITS + 1;
    localparam int STEP_W  = FRACTION_BITS + 2;
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int MAG_W   = COORD_BITS;
    localparam int REM_W   = COORD_BITS + 1;
    localparam int QUO_W   = FRACTION_BITS + 2;
    localparam int LEFT_W  = COORD_BITS + 1;
    localparam int RND_W   = POS_W + 1 - FRACTION_BITS;
    localparam int CMP_W   = (RND_W > DIM_W) ? RND_W : DIM_W;
    localparam int MUL_W   = 2 * DIM_W;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } command_t;

    typedef struct packed {
        logic load_line;
        logic prep;
        logic div_iter;
        logic finish;
        logic step_pixel;
        logic step_idle;
        logic out_load;
    } dda_cmd_t;

    typedef struct packed {
        logic active;
        logic div_done;
        logic out_free;
    } dda_status_t;

endpackage

`default_nettype wire

// ===== rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: joins the controller and the datapath.
//
// Input items arrive on the s_ channel as valid/ready transfers. A load command takes the two
// endpoints and the paint color and produces no result; a step command produces one pixel on
// the m_ channel while a line is active and nothing otherwise. The last pixel carries m_last.
// Screen width and height are written on the cfg_ channel, which is always ready; write it
// only while the block is idle.
// A load occupies the block through the prep, divide and finish states after its transfer:
// the per-axis increments come out of bit-serial dividers that share one divisor and counter
// and produce one quotient bit per cycle for each axis. A step is rounded and clipped in
// its transfer cycle; the row-times-width address multiply follows in the address state.
// The address state keeps s_ready low and loads the output register once that register frees.
// The output register lets the next item be taken while a pixel waits; if the receiver keeps
// m_ready low, the following step holds in the address stage and s_ready stays low until the
// output register frees. Reset clears the line, the output register and sets the screen to
// 640 by 480.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer
    import dda_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [DIM_W-1:0]          cfg_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_command,
    input  wire logic signed [IN_W-1:0]    s_start_x,
    input  wire logic signed [IN_W-1:0]    s_start_y,
    input  wire logic signed [IN_W-1:0]    s_end_x,
    input  wire logic signed [IN_W-1:0]    s_end_y,
    input  wire logic [PAINT_W-1:0]        s_paint,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [PIX_W-1:0]        m_pixel_x,
    output logic signed [PIX_W-1:0]        m_pixel_y,
    output logic                           m_inside_res,
    output logic [ADDR_W-1:0]              m_pixel_address,
    output logic [PAINT_W-1:0]             m_pixel_paint,
    output logic                           m_last
);

    dda_cmd_t    cmd;
    dda_status_t status;

    assign cfg_ready = 1'b1;

    dda_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .cmd       (cmd)
    );

    dda_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_paint         (s_paint),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_inside_res    (m_inside_res),
        .m_pixel_address (m_pixel_address),
        .m_pixel_paint   (m_pixel_paint),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/dda_ctrl.sv =====
// Controller state machine that sequences line loads, the increment division and pixel steps.
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl
    import dda_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire dda_status_t status,
    output dda_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_ADDR = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_LOAD) begin
                        cmd.load_line = 1'b1;
                        state_next    = ST_PREP;
                    end else if (status.active) begin
                        cmd.step_pixel = 1'b1;
                        state_next     = ST_ADDR;
                    end else begin
                        cmd.step_idle = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_iter = 1'b1;
                if (status.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ADDR: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dda_datapath.sv =====
// Datapath with line state, screen registers, the increment divider and the output register.
`timescale 1ns / 1ps
`default_nettype none

module dda_datapath
    import dda_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire dda_cmd_t                  cmd,
    output dda_status_t                    status,
    input  wire logic                      cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [DIM_W-1:0]          cfg_data,
    input  wire logic signed [IN_W-1:0]    s_start_x,
    input  wire logic signed [IN_W-1:0]    s_start_y,
    input  wire logic signed [IN_W-1:0]    s_end_x,
    input  wire logic signed [IN_W-1:0]    s_end_y,
    input  wire logic [PAINT_W-1:0]        s_paint,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [PIX_W-1:0]        m_pixel_x,
    output logic signed [PIX_W-1:0]        m_pixel_y,
    output logic                           m_inside_res,
    output logic [ADDR_W-1:0]              m_pixel_address,
    output logic [PAINT_W-1:0]             m_pixel_paint,
    output logic                           m_last
);

    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;
    logic                      active_reg;
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [STEP_W-1:0]  step_x_reg;
    logic signed [STEP_W-1:0]  step_y_reg;
    logic [LEFT_W-1:0]         left_reg;
    logic [PAINT_W-1:0]        paint_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic [MAG_W-1:0]          side_reg;
    logic [REM_W-1:0]          rem_x_reg;
    logic [REM_W-1:0]          rem_y_reg;
    logic [QUO_W-1:0]          quo_x_reg;
    logic [QUO_W-1:0]          quo_y_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [RND_W-1:0]   rnd_x_reg;
    logic signed [RND_W-1:0]   rnd_y_reg;
    logic                      inside_reg;
    logic                      last_reg;
    logic                      out_valid_reg;

    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic [MAG_W-1:0]             mag_x;
    logic [MAG_W-1:0]             mag_y;
    logic [MAG_W-1:0]             side;
    logic [REM_W-1:0]             side_ext;
    logic                         bit_x;
    logic                         bit_y;
    logic [REM_W-1:0]             rem_x_sub;
    logic [REM_W-1:0]             rem_y_sub;
    logic [QUO_W:0]               quo_x_inc;
    logic [QUO_W:0]               quo_y_inc;
    logic signed [STEP_W-1:0]     stepmag_x;
    logic signed [STEP_W-1:0]     stepmag_y;
    logic signed [POS_W:0]        sum_x;
    logic signed [POS_W:0]        sum_y;
    logic signed [RND_W-1:0]      rnd_x;
    logic signed [RND_W-1:0]      rnd_y;
    logic                         on_screen;
    logic [DIM_W-1:0]             addr_x;
    logic [DIM_W-1:0]             addr_y;
    logic [MUL_W:0]               addr_full;

    assign x0 = signed'(COORD_BITS'($unsigned(s_start_x)));
    assign y0 = signed'(COORD_BITS'($unsigned(s_start_y)));
    assign x1 = signed'(COORD_BITS'($unsigned(s_end_x)));
    assign y1 = signed'(COORD_BITS'($unsigned(s_end_y)));

    assign mag_x    = dx_reg[DELTA_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
    assign mag_y    = dy_reg[DELTA_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
    assign side     = (mag_x >= mag_y) ? mag_x : mag_y;
    assign side_ext = REM_W'(side_reg);

    assign bit_x     = rem_x_reg >= side_ext;
    assign bit_y     = rem_y_reg >= side_ext;
    assign rem_x_sub = bit_x ? rem_x_reg - side_ext : rem_x_reg;
    assign rem_y_sub = bit_y ? rem_y_reg - side_ext : rem_y_reg;

    assign quo_x_inc = {1'b0, quo_x_reg} + (QUO_W + 1)'(1);
    assign quo_y_inc = {1'b0, quo_y_reg} + (QUO_W + 1)'(1);
    assign stepmag_x = signed'(quo_x_inc[QUO_W:1]);
    assign stepmag_y = signed'(quo_y_inc[QUO_W:1]);

    // Round half away from zero: negative values add one less than half before the shift.
    assign sum_x = (POS_W + 1)'(pos_x_reg) + (POS_W + 1)'(1 << (FRACTION_BITS - 1))
                 - (POS_W + 1)'(pos_x_reg[POS_W-1]);
    assign sum_y = (POS_W + 1)'(pos_y_reg) + (POS_W + 1)'(1 << (FRACTION_BITS - 1))
                 - (POS_W + 1)'(pos_y_reg[POS_W-1]);
    assign rnd_x = signed'(sum_x[POS_W:FRACTION_BITS]);
    assign rnd_y = signed'(sum_y[POS_W:FRACTION_BITS]);

    assign on_screen = !rnd_x[RND_W-1] && !rnd_y[RND_W-1]
                     && (CMP_W'($unsigned(rnd_x)) < CMP_W'(width_reg))
                     && (CMP_W'($unsigned(rnd_y)) < CMP_W'(height_reg));

    assign addr_x    = DIM_W'($unsigned(rnd_x_reg));
    assign addr_y    = DIM_W'($unsigned(rnd_y_reg));
    assign addr_full = (MUL_W + 1)'(MUL_W'(addr_y) * MUL_W'(width_reg))
                     + (MUL_W + 1)'(addr_x);

    assign status.active   = active_reg;
    assign status.div_done = cnt_reg == CNT_W'(QUO_W - 1);
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_line) begin
                active_reg <= 1'b1;
            end else if (cmd.step_idle) begin
                active_reg <= 1'b0;
            end else if (cmd.step_pixel && left_reg == LEFT_W'(1)) begin
                active_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_line) begin
            dx_reg    <= DELTA_W'(x1) - DELTA_W'(x0);
            dy_reg    <= DELTA_W'(y1) - DELTA_W'(y0);
            pos_x_reg <= {(POS_W - FRACTION_BITS)'(x0), {FRACTION_BITS{1'b0}}};
            pos_y_reg <= {(POS_W - FRACTION_BITS)'(y0), {FRACTION_BITS{1'b0}}};
            paint_reg <= s_paint;
        end else if (cmd.step_pixel) begin
            pos_x_reg <= pos_x_reg + POS_W'(step_x_reg);
            pos_y_reg <= pos_y_reg + POS_W'(step_y_reg);
        end

        if (cmd.prep) begin
            side_reg  <= side;
            left_reg  <= LEFT_W'(side) + LEFT_W'(1);
            rem_x_reg <= REM_W'(mag_x);
            rem_y_reg <= REM_W'(mag_y);
            quo_x_reg <= '0;
            quo_y_reg <= '0;
            cnt_reg   <= '0;
        end else if (cmd.div_iter) begin
            rem_x_reg <= REM_W'({rem_x_sub, 1'b0});
            rem_y_reg <= REM_W'({rem_y_sub, 1'b0});
            quo_x_reg <= {quo_x_reg[QUO_W-2:0], bit_x};
            quo_y_reg <= {quo_y_reg[QUO_W-2:0], bit_y};
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end else if (cmd.step_pixel) begin
            left_reg <= left_reg - LEFT_W'(1);
        end

        if (cmd.finish) begin
            if (side_reg == '0) begin
                step_x_reg <= '0;
                step_y_reg <= '0;
            end else begin
                step_x_reg <= dx_reg[DELTA_W-1] ? -stepmag_x : stepmag_x;
                step_y_reg <= dy_reg[DELTA_W-1] ? -stepmag_y : stepmag_y;
            end
        end

        if (cmd.step_pixel) begin
            rnd_x_reg  <= rnd_x;
            rnd_y_reg  <= rnd_y;
            inside_reg <= on_screen;
            last_reg   <= left_reg == LEFT_W'(1);
        end

        if (cmd.out_load) begin
            m_pixel_x       <= PIX_W'(rnd_x_reg);
            m_pixel_y       <= PIX_W'(rnd_y_reg);
            m_inside_res    <= inside_reg;
            m_pixel_address <= inside_reg ? ADDR_W'(addr_full) : '0;
            m_pixel_paint   <= paint_reg;
            m_last          <= last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== verif/dda_line_rasterizer_test.sv =====
// Self-checking testbench for the DDA line rasterizer with a pixel scoreboard.
`timescale 1ns / 1ps

module dda_line_rasterizer_test;
    import dda_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int PHASES          = 6;

    typedef struct {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic                    on_screen;
        logic [ADDR_W-1:0]       address;
        logic [PAINT_W-1:0]      paint;
        logic                    last;
    } pixel_t;

    class pixel_scoreboard;
        logic [DIM_W-1:0]   screen_w;
        logic [DIM_W-1:0]   screen_h;
        bit                 drawing;
        logic [POS_W-1:0]   acc_x;
        logic [POS_W-1:0]   acc_y;
        longint             inc_x;
        longint             inc_y;
        longint             pixels_left;
        logic [PAINT_W-1:0] line_color;
        pixel_t             pixel_q[$];
        int                 errors;

        function new();
            screen_w    = SCREEN_WIDTH_RESET;
            screen_h    = SCREEN_HEIGHT_RESET;
            drawing     = 1'b0;
            acc_x       = '0;
            acc_y       = '0;
            inc_x       = 0;
            inc_y       = 0;
            pixels_left = 0;
            line_color  = '0;
            errors      = 0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] value);
            case (idx)
                REG_SCREEN_WIDTH: screen_w = value;
                REG_SCREEN_HEIGHT: screen_h = value;
                default: ;
            endcase
        endfunction

        // Increment per pixel in fixed point, rounded half away from zero.
        function longint increment(longint delta, longint side);
            longint mag;
            longint q;
            if (side == 0) return 0;
            mag = (delta < 0 ? -delta : delta) << FRACTION_BITS;
            q = (2 * mag + side) / (2 * side);
            return delta < 0 ? -q : q;
        endfunction

        function longint round_coord(logic [POS_W-1:0] p);
            longint s;
            longint half;
            s = longint'($signed(p));
            half = longint'(1) << (FRACTION_BITS - 1);
            if (s >= 0) return (s + half) >>> FRACTION_BITS;
            return -((-s + half) >>> FRACTION_BITS);
        endfunction

        function void note_input(command_t cmd, logic signed [IN_W-1:0] sx,
                                 logic signed [IN_W-1:0] sy, logic signed [IN_W-1:0] ex,
                                 logic signed [IN_W-1:0] ey, logic [PAINT_W-1:0] paint);
            longint dx;
            longint dy;
            longint ax;
            longint ay;
            longint side;
            longint px;
            longint py;
            pixel_t want;
            if (cmd == CMD_LOAD) begin
                dx = longint'(ex) - longint'(sx);
                dy = longint'(ey) - longint'(sy);
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                side = ax >= ay ? ax : ay;
                inc_x = increment(dx, side);
                inc_y = increment(dy, side);
                acc_x = POS_W'(longint'(sx) << FRACTION_BITS);
                acc_y = POS_W'(longint'(sy) << FRACTION_BITS);
                pixels_left = side + 1;
                line_color = paint;
                drawing = 1'b1;
                return;
            end
            if (!drawing || pixels_left == 0) begin
                drawing = 1'b0;
                return;
            end
            px = round_coord(acc_x);
            py = round_coord(acc_y);
            want.x = PIX_W'(px);
            want.y = PIX_W'(py);
            want.on_screen = px >= 0 && py >= 0 && px < longint'(screen_w)
                             && py < longint'(screen_h);
            want.address = want.on_screen ? ADDR_W'(py * longint'(screen_w) + px) : '0;
            want.paint = line_color;
            want.last = pixels_left == 1;
            pixel_q.push_back(want);
            acc_x = acc_x + POS_W'(inc_x);
            acc_y = acc_y + POS_W'(inc_y);
            pixels_left--;
            if (pixels_left == 0) drawing = 1'b0;
        endfunction

        function void check(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                $error("Unexpected pixel at (%0d, %0d)", got.x, got.y);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            if (got.x !== want.x) begin
                $error("pixel_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.on_screen !== want.on_screen) begin
                $error("inside_res: expected %0d, got %0d", want.on_screen, got.on_screen);
                errors++;
            end
            if (got.address !== want.address) begin
                $error("pixel_address: expected %0d, got %0d", want.address, got.address);
                errors++;
            end
            if (got.paint !== want.paint) begin
                $error("pixel_paint: expected %h, got %h", want.paint, got.paint);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_reg_t                   cfg_index = REG_SCREEN_WIDTH;
    logic [DIM_W-1:0]           cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    command_t                   s_command = CMD_LOAD;
    logic signed [IN_W-1:0]     s_start_x = '0;
    logic signed [IN_W-1:0]     s_start_y = '0;
    logic signed [IN_W-1:0]     s_end_x = '0;
    logic signed [IN_W-1:0]     s_end_y = '0;
    logic [PAINT_W-1:0]         s_paint = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [PIX_W-1:0]    m_pixel_x;
    logic signed [PIX_W-1:0]    m_pixel_y;
    logic                       m_inside_res;
    logic [ADDR_W-1:0]          m_pixel_address;
    logic [PAINT_W-1:0]         m_pixel_paint;
    logic                       m_last;

    pixel_scoreboard sb = new();
    pixel_t          seen_pixel;
    int              cycle_count = 0;
    int              stall_left = 0;
    bit              tx_burst = 1'b0;
    bit              rx_burst = 1'b0;
    int              screen_w_list[PHASES] = '{1, 4096, 0, 8191, 4096, 320};
    int              screen_h_list[PHASES] = '{1, 4096, 4096, 8191, 0, 200};

    dda_line_rasterizer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_paint         (s_paint),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_inside_res    (m_inside_res),
        .m_pixel_address (m_pixel_address),
        .m_pixel_paint   (m_pixel_paint),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                sb.note_input(s_command, s_start_x, s_start_y, s_end_x, s_end_y, s_paint);
            end
            if (m_valid && m_ready) begin
                seen_pixel.x = m_pixel_x;
                seen_pixel.y = m_pixel_y;
                seen_pixel.on_screen = m_inside_res;
                seen_pixel.address = m_pixel_address;
                seen_pixel.paint = m_pixel_paint;
                seen_pixel.last = m_last;
                sb.check(seen_pixel);
            end
        end
    end

    // After each transfer the receiver may stall at random; in burst mode, which toggles at random, it does not stall.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            stall_left = rx_burst ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_ready <= (stall_left == 0);
    end

    task automatic send_item(command_t cmd, int sx, int sy, int ex, int ey,
                             logic [PAINT_W-1:0] paint);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_start_x <= IN_W'(sx);
        s_start_y <= IN_W'(sy);
        s_end_x   <= IN_W'(ex);
        s_end_y   <= IN_W'(ey);
        s_paint   <= paint;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_line(int sx, int sy, int ex, int ey, logic [PAINT_W-1:0] paint);
        send_item(CMD_LOAD, sx, sy, ex, ey, paint);
    endtask

    task automatic step_pixel();
        send_item(CMD_STEP, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_screen(int w, int h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_lines(int count);
        int drawn;
        int kind;
        int cut;
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int ax;
        int ay;
        int side;
        int n_steps;
        drawn = 0;
        while (drawn < count) begin
            w = sb.screen_w;
            h = sb.screen_h;
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                repeat ($urandom_range(1, 2)) step_pixel();
                continue;
            end
            if (kind < 20) begin
                x0 = $urandom_range(0, 65535) - 32768;
                y0 = $urandom_range(0, 65535) - 32768;
                x1 = $urandom_range(0, 65535) - 32768;
                y1 = $urandom_range(0, 65535) - 32768;
            end else begin
                if (kind < 65) begin
                    x0 = $urandom_range(0, w + 16) - 8;
                    y0 = $urandom_range(0, h + 16) - 8;
                end else begin
                    x0 = w - $urandom_range(0, 12);
                    y0 = h - $urandom_range(0, 12);
                end
                x1 = x0 + $urandom_range(0, 24) - 12;
                y1 = y0 + $urandom_range(0, 24) - 12;
            end
            ax = x1 > x0 ? x1 - x0 : x0 - x1;
            ay = y1 > y0 ? y1 - y0 : y0 - y1;
            side = ax >= ay ? ax : ay;
            cut = $urandom_range(0, 9);
            if (kind < 20) n_steps = $urandom_range(1, 4);
            else if (cut == 0) n_steps = $urandom_range(0, side);
            else if (cut == 1) n_steps = side + 1 + $urandom_range(1, 2);
            else n_steps = side + 1;
            load_line(x0, y0, x1, y1, $urandom);
            repeat (n_steps) step_pixel();
            drawn += 1 + (n_steps < side + 1 ? n_steps : side + 1);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        step_pixel();
        load_line(5, 7, 5, 7, 32'h1122_3344);
        repeat (2) step_pixel();
        load_line(0, 0, 4, 2, 32'hA5A5_5A5A);
        repeat (5) step_pixel();
        load_line(1, 1, -3, -1, 32'h0000_0001);
        repeat (5) step_pixel();
        load_line(638, 478, 640, 480, 32'h8000_0000);
        repeat (3) step_pixel();
        load_line(-32768, 32767, 32767, -32768, 32'hFFFF_FFFF);
        step_pixel();
        load_line(32767, 32767, -32768, -32768, 32'h0000_0000);
        step_pixel();
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            write_screen(screen_w_list[phase], screen_h_list[phase]);
            run_lines(ITEMS_PER_PHASE);
            settle();
        end

        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dda_pkg.sv
rtl/dda_ctrl.sv
rtl/dda_datapath.sv
rtl/dda_line_rasterizer.sv
verif/dda_line_rasterizer_test.sv
